// ===== design/dfr_pkg.sv =====
// Shared types, codes and helpers for the debug packet deframer.
package dfr_pkg;

    localparam logic [7:0] CHAR_START   = 8'h24; // '$'
    localparam logic [7:0] CHAR_END     = 8'h23; // '#'
    localparam logic [7:0] ESC_DEFAULT  = 8'h7D; // '}'
    localparam logic [7:0] ESC_XOR      = 8'h20;
    localparam logic [7:0] CHAR_ZERO    = 8'h30; // '0'
    localparam logic [7:0] CHAR_LOWER_A = 8'h61; // 'a'
    localparam logic [7:0] CHAR_UPPER_A = 8'h41; // 'A'

    localparam logic [15:0] MAX_PAYLOAD_DEFAULT = 16'd1024;

    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ESCAPE_CHAR = 1'b0,
        CFG_MAX_PAYLOAD = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2,
        KIND_LONG = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_DATA = 5'b00010,
        PH_ESC  = 5'b00100,
        PH_CK0  = 5'b01000,
        PH_CK1  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  data;
        logic [15:0] len;
    } dfr_result_t;

    typedef struct packed {
        logic       bad;
        logic [3:0] value;
    } hex_digit_t;

    // ASCII hex digit to nibble; bad flag set for anything else
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t r;
        logic [7:0] d;
        r.bad   = 1'b0;
        r.value = 4'd0;
        d       = 8'd0;
        if (c >= CHAR_ZERO && c <= CHAR_ZERO + 8'd9) begin
            d       = c - CHAR_ZERO;
            r.value = d[3:0];
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_A + 8'd5) begin
            d       = c - CHAR_LOWER_A + 8'd10;
            r.value = d[3:0];
        end
        else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_A + 8'd5) begin
            d       = c - CHAR_UPPER_A + 8'd10;
            r.value = d[3:0];
        end
        else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== design/debug_packet_deframer.sv =====
// Top level of the debug packet deframer: config registers, framing core, result buffer.
//
//  channel  direction  handshake           payload
//  -------  ---------  ------------------  --------------------------------
//  input    in         in_valid/in_stall   rx_byte
//  output   out        out_valid/out_stall kind, data_byte, payload_length
//  config   in         cfg_we              cfg_index, cfg_data
//
// One byte per cycle while in_stall is low. Each beat is decoded in the cycle it is taken
// and its result, if any, is registered in the result register (the skid stage if stalled).
// Reset puts the framer in hunt and loads escape '}' and a 1024-byte limit.
// When the output is stalled a second result parks in the skid stage; only
// then is in_stall raised, straight from that register.
// Config writes are taken every cycle and apply from the next beat on.
module debug_packet_deframer
    import dfr_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               rx_byte,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               kind,
    output logic [7:0]               data_byte,
    output logic [15:0]              payload_length,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic [7:0]  escape_reg;
    logic [15:0] max_payload_reg;
    logic        beat;
    logic        full;
    dfr_result_t res;
    dfr_result_t out_beat;

    // config register file; no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg      <= ESC_DEFAULT;
            max_payload_reg <= MAX_PAYLOAD_DEFAULT;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ESCAPE_CHAR: escape_reg      <= cfg_data[7:0];
                CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    // a beat is taken whenever the skid stage is free
    assign in_stall = full;
    assign beat     = in_valid && !full;

    dfr_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat        (beat),
        .rx_byte     (rx_byte),
        .escape_char (escape_reg),
        .max_payload (max_payload_reg),
        .res         (res)
    );

    dfr_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat)
    );

    assign kind           = 2'(out_beat.kind);
    assign data_byte      = out_beat.data;
    assign payload_length = out_beat.len;

endmodule

// ===== design/dfr_core.sv =====
// Framing state and per-beat decode of the debug packet deframer.
module dfr_core
    import dfr_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              beat,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        escape_char,
    input  logic [15:0]       max_payload,
    output dfr_result_t       res
);

    localparam int CMP_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [CMP_BITS-1:0] COUNT_MASK = CMP_BITS'({COUNT_BITS{1'b1}});

    phase_t                phase_reg,       phase_next;
    logic [7:0]            sum_reg,         sum_next;
    logic [3:0]            digit_reg,       digit_next;
    logic                  digit_bad_reg,   digit_bad_next;
    logic [COUNT_BITS-1:0] count_reg,       count_next;

    logic [CMP_BITS-1:0] count_ext;
    logic [CMP_BITS-1:0] max_ext;
    logic [CMP_BITS-1:0] limit;
    logic                overflow;
    logic [7:0]          decoded;
    hex_digit_t          hex;
    logic                take;

    // limit is max_payload capped at the count's range
    assign count_ext = CMP_BITS'(count_reg);
    assign max_ext   = CMP_BITS'(max_payload);
    assign limit     = (max_ext > COUNT_MASK) ? COUNT_MASK : max_ext;
    assign overflow  = (count_ext >= limit);
    assign decoded   = (phase_reg == PH_ESC) ? (rx_byte ^ ESC_XOR) : rx_byte;
    assign hex       = hex_decode(rx_byte);

    always_comb
    begin
        phase_next     = phase_reg;
        sum_next       = sum_reg;
        digit_next     = digit_reg;
        digit_bad_next = digit_bad_reg;
        count_next     = count_reg;
        take           = 1'b0;
        res.valid      = 1'b0;
        res.kind       = KIND_BYTE;
        res.data       = 8'd0;
        res.len        = 16'd0;

        if (beat)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == CHAR_START)
                    begin
                        phase_next     = PH_DATA;
                        sum_next       = 8'd0;
                        count_next     = '0;
                        digit_next     = 4'd0;
                        digit_bad_next = 1'b0;
                    end
                end
                PH_DATA:
                begin
                    if (rx_byte == CHAR_END)
                        phase_next = PH_CK0;
                    else if (rx_byte == escape_char)
                    begin
                        sum_next   = sum_reg + rx_byte;
                        phase_next = PH_ESC;
                    end
                    else
                        take = 1'b1;
                end
                PH_ESC:
                begin
                    phase_next = PH_DATA;
                    take       = 1'b1;
                end
                PH_CK0:
                begin
                    digit_next     = hex.value;
                    digit_bad_next = hex.bad;
                    phase_next     = PH_CK1;
                end
                PH_CK1:
                begin
                    phase_next = PH_HUNT;
                    res.valid  = 1'b1;
                    res.len    = 16'(count_reg);
                    if (hex.bad || digit_bad_reg || ({digit_reg, hex.value} != sum_reg))
                        res.kind = KIND_BAD;
                    else
                        res.kind = KIND_GOOD;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase

            if (take)
            begin
                res.valid = 1'b1;
                if (overflow)
                begin
                    res.kind   = KIND_LONG;
                    res.len    = 16'(count_reg);
                    phase_next = PH_HUNT;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    sum_next   = sum_reg + rx_byte;
                    res.data   = decoded;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            sum_reg       <= 8'd0;
            digit_reg     <= 4'd0;
            digit_bad_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            sum_reg       <= sum_next;
            digit_reg     <= digit_next;
            digit_bad_reg <= digit_bad_next;
            count_reg     <= count_next;
        end
    end

endmodule

// ===== design/dfr_out_skid.sv =====
// Result register with a one-entry skid stage.
module dfr_out_skid
    import dfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dfr_result_t res,
    output logic        full,
    output logic        out_valid,
    input  logic        out_stall,
    output dfr_result_t out_beat
);

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    dfr_result_t out_reg,  out_next;
    dfr_result_t skid_reg, skid_next;
    logic        pop;

    assign pop = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            // input is held off, so nothing new arrives here
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_next       = res;
            out_valid_next = res.valid;
        end
        else if (res.valid)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

endmodule

// ===== design/dfr_checker.sv =====
// Port-level checks for the debug packet deframer, bound to the top level.
module dfr_checker
    import dfr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [7:0]  data_byte,
    input logic [15:0] payload_length
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_byte)
            && $stable(payload_length))
        else $error("stalled result beat changed");

    // input is only held off while a result is waiting
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("in_stall without a pending result");

    a_byte_no_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_BYTE) |-> payload_length == 16'd0)
        else $error("payload byte carries a length");

    a_end_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_BYTE) |-> data_byte == 8'd0)
        else $error("end result carries data");

endmodule

bind debug_packet_deframer dfr_checker u_dfr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .data_byte      (data_byte),
    .payload_length (payload_length)
);
